/* rtl/velocity_autocorrelator_macros.svh */
// Assertion macros shared by the velocity autocorrelator RTL.
`ifndef VELOCITY_AUTOCORRELATOR_MACROS_SVH
`define VELOCITY_AUTOCORRELATOR_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold whenever reset is low.
`define VA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Condition that must never be true outside reset.
`define VA_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define VA_ASSERT(label, clk, rst, prop)
`define VA_NEVER(label, clk, rst, cond)
`endif
`endif

/* rtl/va_pkg.sv */
// Types and constants shared by the velocity autocorrelator modules.
package va_pkg;

   // Request codes carried in req_type.
   localparam logic [1:0] REQ_SAMPLE  = 2'd0;
   localparam logic [1:0] REQ_RESTART = 2'd1;
   localparam logic [1:0] REQ_READ    = 2'd2;
   localparam logic [1:0] REQ_UNUSED  = 2'd3;

   // Depth of the command queue between front and back.
   localparam int Q_DEPTH = 2;

   localparam logic [39:0] COUNT_MAX = 40'hFF_FFFF_FFFF;
   localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [9:0]         particle_index;
      logic               frame_end;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] vel_z;
      logic [5:0]         read_lag;
   } va_req_type;

   typedef struct packed {
      logic [5:0]         lag_out;
      logic signed [63:0] corr_sum;
      logic [39:0]        sample_count;
   } va_rsp_type;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_RESTART,
      OP_READ
   } va_op_type;

   // Classified command handed from front to back.
   typedef struct packed {
      va_op_type   op;
      logic        in_range;
      logic        frame_end;
      logic [15:0] particle;
      logic [47:0] vel;
      logic [5:0]  lag;
   } va_cmd_type;

   typedef struct packed {
      logic [1:0] count;
      logic       full;
   } va_fstat_type;

   typedef struct packed {
      logic idle;
      logic pipe_busy;
   } va_bstat_type;

endpackage

/* rtl/va_front.sv */
// Front end: accepts requests, classifies them and queues commands.
module va_front #(
   parameter int MAX_PARTICLES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  va_pkg::va_req_type req_data,
   output logic               cmd_valid,
   output va_pkg::va_cmd_type cmd,
   input  logic               cmd_pop,
   output va_pkg::va_fstat_type stat
);

   va_pkg::va_cmd_type q_ff [va_pkg::Q_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept, push;
   va_pkg::va_cmd_type new_cmd;

   assign req_ready = (count_ff != 2'(va_pkg::Q_DEPTH));
   assign accept    = req_valid && req_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.full  = !req_ready;

   // Decode the request into a command; the unused code is dropped.
   always_comb begin
      new_cmd.in_range  = ({7'd0, req_data.particle_index} < 17'(MAX_PARTICLES));
      new_cmd.frame_end = req_data.frame_end;
      new_cmd.particle  = {6'd0, req_data.particle_index};
      new_cmd.vel       = {req_data.vel_z, req_data.vel_y, req_data.vel_x};
      new_cmd.lag       = req_data.read_lag;
      push              = accept;
      unique case (req_data.req_type)
         va_pkg::REQ_SAMPLE:  new_cmd.op = va_pkg::OP_SAMPLE;
         va_pkg::REQ_RESTART: new_cmd.op = va_pkg::OP_RESTART;
         va_pkg::REQ_READ:    new_cmd.op = va_pkg::OP_READ;
         default: begin
            new_cmd.op = va_pkg::OP_READ;
            push       = 1'b0;
         end
      endcase
   end

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

/* rtl/va_back.sv */
// Back end: history ring, per-lag correlation pipeline and read path.
module va_back #(
   parameter int MAX_LAGS      = 64,
   parameter int MAX_PARTICLES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_data,
   input  logic               cmd_valid,
   input  va_pkg::va_cmd_type cmd,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output va_pkg::va_rsp_type rsp_data,
   output va_pkg::va_bstat_type stat
);

   localparam int LW     = $clog2(MAX_LAGS);
   localparam int LCW    = $clog2(MAX_LAGS + 1);
   localparam int PW     = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int HW     = PW + LW;
   localparam int HDEPTH = MAX_PARTICLES * (2 ** LW);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_SAMPLE,
      ST_DRAIN,
      ST_RADDR,
      ST_RDATA
   } state_type;

   state_type state_ff;
   va_pkg::va_cmd_type cmd_ff;
   logic [6:0]     cfg_ff;
   logic           dirty_ff;
   logic [31:0]    frames_ff;
   logic [LW-1:0]  cur_ff, k_ff, slot_ff, top_ff;
   logic [LCW-1:0] rem_ff, rem_in;
   logic [4:0]     mbit_ff;
   logic           rsp_valid_ff;
   va_pkg::va_rsp_type rsp_data_ff;
   logic           a_valid_ff, a_first_ff;
   logic [LW-1:0]  a_k_ff;

   logic                b_valid_ff;
   logic [LW-1:0]       b_k_ff;
   logic signed [31:0]  px_ff, py_ff, pz_ff;
   logic signed [63:0]  b_acc_ff;
   logic [39:0]         b_cnt_ff;

   logic [47:0] hist_mem [HDEPTH];
   logic [63:0] acc_mem  [MAX_LAGS];
   logic [39:0] cnt_mem  [MAX_LAGS];
   logic        vld_ff   [MAX_LAGS];
   logic [47:0] hist_q;
   logic [63:0] acc_q;
   logic [39:0] cnt_q;
   logic        vld_q;

   logic [LCW-1:0] lags;
   logic [LW-1:0]  lags_m1;
   logic [8:0]     cfg_ext, lag_ext;
   logic [LW-1:0]  lag_idx;
   logic           lag_ok;
   logic [PW-1:0]  pidx;
   logic [LCW:0]   shifted;
   logic           csr_acc, restart, hist_we, out_free;
   logic [HW-1:0]  hist_waddr, hist_raddr;
   logic [LW-1:0]  acc_raddr;
   logic [47:0]    h;
   logic signed [33:0] dot;
   logic signed [64:0] sum65;
   logic signed [63:0] acc_next;
   logic [39:0]        cnt_next;
   logic [31:0]        frames_inc;

   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid && csr_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign stat.idle      = (state_ff == ST_IDLE);
   assign stat.pipe_busy = a_valid_ff || b_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Effective lag count: zero acts as one, large values clamp.
   always_comb begin
      cfg_ext = {2'd0, cfg_ff};
      if (cfg_ext == 9'd0) begin
         lags = LCW'(1);
      end else if (cfg_ext > 9'(MAX_LAGS)) begin
         lags = LCW'(MAX_LAGS);
      end else begin
         lags = LCW'(cfg_ext);
      end
      lags_m1 = LW'(lags - LCW'(1));
   end

   // Read lag decode and particle address.
   always_comb begin
      lag_ext = {3'd0, cmd_ff.lag};
      lag_idx = lag_ext[LW-1:0];
      lag_ok  = (lag_ext < 9'(MAX_LAGS));
      pidx    = (state_ff == ST_IDLE) ? cmd.particle[PW-1:0] : cmd_ff.particle[PW-1:0];
   end

   // One restoring step of frames_seen mod lags.
   always_comb begin
      shifted = {rem_ff, frames_ff[mbit_ff]};
      if (shifted >= {1'b0, lags}) begin
         rem_in = LCW'(shifted - {1'b0, lags});
      end else begin
         rem_in = LCW'(shifted);
      end
   end

   // Command pop, history write and memory addresses.
   always_comb begin
      cmd_pop    = (state_ff == ST_IDLE) && !dirty_ff && cmd_valid;
      restart    = cmd_pop && (cmd.op == va_pkg::OP_RESTART);
      hist_we    = cmd_pop && (cmd.op == va_pkg::OP_SAMPLE) && cmd.in_range;
      hist_waddr = {pidx, cur_ff};
      hist_raddr = {pidx, slot_ff};
      acc_raddr  = (state_ff == ST_SAMPLE) ? k_ff : lag_idx;
      frames_inc = frames_ff + 32'd1;
   end

   // Last stage: sum the products and update the lag accumulator.
   always_comb begin
      dot   = 34'(px_ff) + 34'(py_ff) + 34'(pz_ff);
      sum65 = 65'(b_acc_ff) + 65'(dot);
      if (sum65[64] != sum65[63]) begin
         acc_next = sum65[64] ? va_pkg::SUM_MIN : va_pkg::SUM_MAX;
      end else begin
         acc_next = sum65[63:0];
      end
      cnt_next = (b_cnt_ff == va_pkg::COUNT_MAX) ? b_cnt_ff : b_cnt_ff + 40'd1;
   end

   // Control state machine and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= 7'd64;
         dirty_ff     <= 1'b1;
         frames_ff    <= 32'd0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         a_valid_ff   <= 1'b0;
      end else begin
         a_valid_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_acc) begin
            cfg_ff <= csr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               rem_ff  <= '0;
               mbit_ff <= 5'd31;
               if (dirty_ff) begin
                  state_ff <= ST_MOD;
               end else if (cmd_valid) begin
                  cmd_ff <= cmd;
                  unique case (cmd.op)
                     va_pkg::OP_SAMPLE: begin
                        k_ff    <= '0;
                        slot_ff <= cur_ff;
                        top_ff  <= (frames_ff < 32'(lags)) ? LW'(frames_ff) : lags_m1;
                        state_ff <= cmd.in_range ? ST_SAMPLE : ST_DRAIN;
                     end
                     va_pkg::OP_RESTART: begin
                        frames_ff <= 32'd0;
                        cur_ff    <= '0;
                     end
                     default: state_ff <= ST_RADDR;
                  endcase
               end
            end
            ST_MOD: begin
               rem_ff  <= rem_in;
               mbit_ff <= mbit_ff - 5'd1;
               if (mbit_ff == 5'd0) begin
                  cur_ff   <= LW'(rem_in);
                  state_ff <= ST_IDLE;
               end
            end
            ST_SAMPLE: begin
               a_valid_ff <= 1'b1;
               a_first_ff <= (k_ff == '0);
               a_k_ff     <= k_ff;
               k_ff       <= k_ff + LW'(1);
               slot_ff    <= (slot_ff == '0) ? lags_m1 : slot_ff - LW'(1);
               if (k_ff == top_ff) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!a_valid_ff && !b_valid_ff) begin
                  if (cmd_ff.op == va_pkg::OP_SAMPLE && cmd_ff.frame_end) begin
                     frames_ff <= frames_inc;
                     if (frames_inc == 32'd0 || cur_ff == lags_m1) begin
                        cur_ff <= '0;
                     end else begin
                        cur_ff <= cur_ff + LW'(1);
                     end
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_RADDR: state_ff <= ST_RDATA;
            ST_RDATA: begin
               if (out_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_data_ff.lag_out  <= cmd_ff.lag;
                  rsp_data_ff.corr_sum <= (lag_ok && vld_q) ? $signed(acc_q) : 64'sd0;
                  rsp_data_ff.sample_count <= (lag_ok && vld_q) ? cnt_q : 40'd0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         // A write during the remainder pass makes another pass follow it.
         if (csr_acc) begin
            dirty_ff <= 1'b1;
         end else if (state_ff == ST_IDLE && dirty_ff) begin
            dirty_ff <= 1'b0;
         end
      end
   end

   // Products of the new velocity with the stored one.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      px_ff    <= $signed(cmd_ff.vel[15:0])  * $signed(h[15:0]);
      py_ff    <= $signed(cmd_ff.vel[31:16]) * $signed(h[31:16]);
      pz_ff    <= $signed(cmd_ff.vel[47:32]) * $signed(h[47:32]);
      b_acc_ff <= vld_q ? $signed(acc_q) : 64'sd0;
      b_cnt_ff <= vld_q ? cnt_q : 40'd0;
      b_k_ff   <= a_k_ff;
   end

   // Lag zero pairs the sample with itself.
   assign h = a_first_ff ? cmd_ff.vel : hist_q;

   // Per-lag valid bits; restart clears every lag at once.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_LAGS; i++) begin
         if (reset || restart) begin
            vld_ff[i] <= 1'b0;
         end else if (b_valid_ff && b_k_ff == LW'(i)) begin
            vld_ff[i] <= 1'b1;
         end
      end
   end

   // Velocity history memory.
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= cmd.vel;
      end
      hist_q <= hist_mem[hist_raddr];
   end

   // Accumulator and count memories.
   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         acc_mem[b_k_ff] <= acc_next;
         cnt_mem[b_k_ff] <= cnt_next;
      end
      acc_q <= acc_mem[acc_raddr];
      cnt_q <= cnt_mem[acc_raddr];
      vld_q <= vld_ff[acc_raddr];
   end

endmodule

/* rtl/velocity_autocorrelator.sv */
// Top level of the velocity autocorrelator.
// A sample leaves the queue, updates each lag in turn (up to the lags in use,
// so at most MAX_LAGS) and then drains the read, multiply and accumulate
// pipeline. Restart takes effect as it leaves the queue; a read passes an
// address state and a data state, and its result is registered once the
// output is free. After a write to lags_in_use, and after reset, a remainder
// pass over the 32 frame-count bits recomputes the ring slot before the next
// item starts. The front queue holds two items, so requests keep flowing in
// while the back end works and while a read result waits, until it is full.
`include "velocity_autocorrelator_macros.svh"
module velocity_autocorrelator #(
   parameter int MAX_LAGS      = 64,
   parameter int MAX_PARTICLES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  va_pkg::va_req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output va_pkg::va_rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_data
);

   logic                 cmd_valid, cmd_pop;
   va_pkg::va_cmd_type   cmd;
   va_pkg::va_fstat_type fstat;
   va_pkg::va_bstat_type bstat;

   // Request intake and command queue.
   va_front #(
      .MAX_PARTICLES(MAX_PARTICLES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_pop(cmd_pop),
      .stat(fstat)
   );

   // Correlation engine.
   va_back #(
      .MAX_LAGS(MAX_LAGS),
      .MAX_PARTICLES(MAX_PARTICLES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_pop(cmd_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .stat(bstat)
   );

   // The back end only returns to idle with an empty pipeline.
   `VA_ASSERT(a_idle_drained, clock, reset, bstat.idle |-> !bstat.pipe_busy)
   // The queue never holds more than its depth.
   `VA_NEVER(a_queue_over, clock, reset, fstat.count > 2'(va_pkg::Q_DEPTH))
   // A queued command is never popped from an empty queue.
   `VA_NEVER(a_pop_empty, clock, reset, cmd_pop && fstat.count == 2'd0)

endmodule
